// File: rtl/ddms_pkg.sv
// Shared constants, register and operation codes, and control structs for the drive mixer.
package ddms_pkg;

  localparam int RC_BITS      = 12;
  localparam int DRIVE_BITS   = 11;
  localparam int CENTER_BITS  = 12;
  localparam int RANGE_BITS   = 12;
  localparam int PWM_BITS     = 10;
  localparam int CFG_BITS     = 12;
  localparam int CFG_IDX_BITS = 3;
  localparam int OP_BITS      = 2;

  localparam int CTR_BITS  = (RC_BITS > CENTER_BITS) ? RC_BITS : CENTER_BITS;
  localparam int MAG_BITS  = CTR_BITS + PWM_BITS;
  localparam int CNT_BITS  = $clog2(MAG_BITS);
  localparam int DRIVE_MAX = 2 ** (DRIVE_BITS - 1) - 1;
  localparam int SC_BITS   = PWM_BITS + 1;
  localparam int MIX_BITS  = PWM_BITS + 2;
  localparam int SLEW_BITS = ((DRIVE_BITS > SC_BITS) ? DRIVE_BITS : SC_BITS) + 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPAN      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PWM_MAX   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEADZONE  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLEW_RATE = 3'd4;

  localparam logic [OP_BITS-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_BITS-1:0] OP_STOP   = 2'd1;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic div_step;
    logic scale;
    logic mix;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic update;
  } status_t;

endpackage

// File: rtl/ddms_div.sv
// Restoring unsigned divider, one quotient bit per step.
module ddms_div (
  input  logic                           clk,
  input  logic                           start,
  input  logic                           step,
  input  logic [ddms_pkg::MAG_BITS-1:0]  dividend,
  input  logic [ddms_pkg::RANGE_BITS-1:0] divisor,
  output logic [ddms_pkg::MAG_BITS-1:0]  quotient
);

  logic [ddms_pkg::RANGE_BITS-1:0] rem;
  logic [ddms_pkg::RANGE_BITS:0]   trial;
  logic                            fits;

  assign trial = {rem, quotient[ddms_pkg::MAG_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (step) begin
      rem      <= fits ? ddms_pkg::RANGE_BITS'(trial - {1'b0, divisor})
                       : ddms_pkg::RANGE_BITS'(trial);
      quotient <= {quotient[ddms_pkg::MAG_BITS-2:0], fits};
    end
  end

endmodule

// File: rtl/ddms_ctrl.sv
// Sequencer for the drive mixer: handshakes, divider stepping, output word valid.
module ddms_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  ddms_pkg::status_t   status,
  output ddms_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_MIX   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]                    state, state_next;
  logic [ddms_pkg::CNT_BITS-1:0] cnt, cnt_next;
  logic                          out_valid_next;
  logic                          accept;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (status.update) begin
          cmd.mul    = 1'b1;
          state_next = S_INIT;
        end else begin
          state_next = S_MIX;
        end
      end
      S_INIT: begin
        cmd.div_start = 1'b1;
        cnt_next      = ddms_pkg::CNT_BITS'(ddms_pkg::MAG_BITS - 1);
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == '0) state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_MIX;
      end
      S_MIX: begin
        cmd.mix    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/ddms_dp.sv
// Datapath: config registers, centering, scaling, mixing, slew limiting, output word.
module ddms_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ddms_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ddms_pkg::CFG_BITS-1:0]        cfg_data,
  input  logic [ddms_pkg::OP_BITS-1:0]         operation,
  input  logic [ddms_pkg::RC_BITS-1:0]         steer_raw,
  input  logic [ddms_pkg::RC_BITS-1:0]         throttle_raw,
  input  ddms_pkg::cmd_t                       cmd,
  output ddms_pkg::status_t                    status,
  output logic signed [ddms_pkg::DRIVE_BITS-1:0] left_drive,
  output logic signed [ddms_pkg::DRIVE_BITS-1:0] right_drive,
  output logic                                 drivers_enabled
);

  localparam int PB = ddms_pkg::PWM_BITS;
  localparam int SB = ddms_pkg::SLEW_BITS;
  localparam int DB = ddms_pkg::DRIVE_BITS;
  localparam int CB = ddms_pkg::CTR_BITS;
  localparam int MB = ddms_pkg::MAG_BITS;

  logic [ddms_pkg::CENTER_BITS-1:0] stick_center;
  logic [ddms_pkg::RANGE_BITS-1:0]  stick_span;
  logic [PB-1:0]                    pwm_max, deadzone, slew_rate;

  logic signed [DB-1:0] left_output, right_output;
  logic                 enable_flag;

  logic [ddms_pkg::OP_BITS-1:0] op_q;
  logic [ddms_pkg::RC_BITS-1:0] steer_q, throt_q;

  logic [PB-1:0]                   lim;
  logic [ddms_pkg::RANGE_BITS-1:0] divisor;
  logic [CB-1:0]                   ctr_ext, s_ext, t_ext;
  logic [MB-1:0]                   s_prod, t_prod, s_quo, t_quo;
  logic                            s_neg, t_neg;
  logic signed [ddms_pkg::SC_BITS-1:0]  s_sc, t_sc, l_tgt, r_tgt;
  logic signed [ddms_pkg::MIX_BITS-1:0] l_sum, r_sum;

  function automatic logic signed [ddms_pkg::SC_BITS-1:0] scale_fn(
    input logic [MB-1:0] q, input logic neg, input logic [PB-1:0] lm,
    input logic [PB-1:0] dz);
    logic [PB-1:0] mag;
    mag = (q > MB'(lm)) ? lm : q[PB-1:0];
    if (mag < dz) mag = '0;
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [ddms_pkg::SC_BITS-1:0] clamp_mix(
    input logic signed [ddms_pkg::MIX_BITS-1:0] v, input logic [PB-1:0] lm);
    logic signed [ddms_pkg::MIX_BITS-1:0] hi;
    hi = $signed({2'b00, lm});
    if (v > hi) return ddms_pkg::SC_BITS'(hi);
    if (v < -hi) return ddms_pkg::SC_BITS'(-hi);
    return ddms_pkg::SC_BITS'(v);
  endfunction

  function automatic logic signed [DB-1:0] clamp_out(
    input logic signed [DB-1:0] v, input logic [PB-1:0] lm);
    logic signed [SB-1:0] w, hi;
    w  = SB'(v);
    hi = $signed(SB'(lm));
    if (w > hi) w = hi;
    else if (w < -hi) w = -hi;
    return DB'(w);
  endfunction

  function automatic logic signed [DB-1:0] slew_fn(
    input logic signed [DB-1:0] cur, input logic signed [ddms_pkg::SC_BITS-1:0] tgt,
    input logic [PB-1:0] rate);
    logic signed [SB-1:0] c, t, n, st;
    c  = SB'(cur);
    t  = SB'(tgt);
    st = $signed(SB'(rate));
    if ((c > 0 && t < 0) || (c < 0 && t > 0)) t = '0;
    n = c;
    if (c < t) begin
      n = c + st;
      if (n > t) n = t;
    end else if (c > t) begin
      n = c - st;
      if (n < t) n = t;
    end
    return DB'(n);
  endfunction

  assign lim = (32'(pwm_max) > ddms_pkg::DRIVE_MAX) ? PB'(ddms_pkg::DRIVE_MAX) : pwm_max;
  assign divisor = (stick_span == '0) ? ddms_pkg::RANGE_BITS'(1) : stick_span;
  assign status.update = op_q == ddms_pkg::OP_UPDATE;

  assign ctr_ext = CB'(stick_center);
  assign s_ext   = CB'(steer_q);
  assign t_ext   = CB'(throt_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_center <= ddms_pkg::CENTER_BITS'(1500);
      stick_span   <= ddms_pkg::RANGE_BITS'(500);
      pwm_max      <= PB'(255);
      deadzone     <= PB'(10);
      slew_rate    <= PB'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ddms_pkg::REG_CENTER:    stick_center <= cfg_data[ddms_pkg::CENTER_BITS-1:0];
        ddms_pkg::REG_SPAN:      stick_span   <= cfg_data[ddms_pkg::RANGE_BITS-1:0];
        ddms_pkg::REG_PWM_MAX:   pwm_max      <= cfg_data[PB-1:0];
        ddms_pkg::REG_DEADZONE:  deadzone     <= cfg_data[PB-1:0];
        ddms_pkg::REG_SLEW_RATE: slew_rate    <= cfg_data[PB-1:0];
        default: ;
      endcase
    end
  end

  // input capture, centered magnitude times pwm_max, scaled values, output word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      steer_q <= steer_raw;
      throt_q <= throttle_raw;
    end
    if (cmd.mul) begin
      s_neg  <= s_ext < ctr_ext;
      t_neg  <= t_ext < ctr_ext;
      s_prod <= MB'((s_ext < ctr_ext) ? ctr_ext - s_ext : s_ext - ctr_ext) * MB'(pwm_max);
      t_prod <= MB'((t_ext < ctr_ext) ? ctr_ext - t_ext : t_ext - ctr_ext) * MB'(pwm_max);
    end
    if (cmd.scale) begin
      s_sc <= scale_fn(s_quo, s_neg, lim, deadzone);
      t_sc <= scale_fn(t_quo, t_neg, lim, deadzone);
    end
    if (cmd.emit) begin
      left_drive      <= clamp_out(left_output, lim);
      right_drive     <= clamp_out(right_output, lim);
      drivers_enabled <= enable_flag;
    end
  end

  ddms_div u_div_steer (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (s_prod),
    .divisor  (divisor),
    .quotient (s_quo)
  );

  ddms_div u_div_throttle (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (t_prod),
    .divisor  (divisor),
    .quotient (t_quo)
  );

  always_comb begin
    l_sum = ddms_pkg::MIX_BITS'(t_sc) + ddms_pkg::MIX_BITS'(s_sc);
    r_sum = ddms_pkg::MIX_BITS'(t_sc) - ddms_pkg::MIX_BITS'(s_sc);
    if (status.update) begin
      l_tgt = clamp_mix(l_sum, lim);
      r_tgt = clamp_mix(r_sum, lim);
    end else begin
      l_tgt = '0;
      r_tgt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_output  <= '0;
      right_output <= '0;
      enable_flag  <= 1'b1;
    end else if (cmd.mix) begin
      priority if (op_q == ddms_pkg::OP_UPDATE || op_q == ddms_pkg::OP_STOP) begin
        left_output  <= slew_fn(left_output, l_tgt, slew_rate);
        right_output <= slew_fn(right_output, r_tgt, slew_rate);
        if (status.update) enable_flag <= 1'b1;
      end else begin
        left_output  <= '0;
        right_output <= '0;
        enable_flag  <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/differential_drive_mixer_slew_core.sv
// Top level of the differential drive mixer with slew-rate limit.
//
//   channel   handshake            payload
//   input     in_valid / in_stall  operation, steer_raw, throttle_raw
//   output    out_valid / out_stall left_drive, right_drive, drivers_enabled
//   config    cfg_we               cfg_index, cfg_data
//
// An update word is computed by the two bit-serial dividers running side by side;
// soft stop and failsafe skip the dividers.
// A new input word is taken while the previous result waits on out_stall.
// Synchronous reset restores the register defaults, zero internal drive, enable flag set.
module differential_drive_mixer_slew_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [ddms_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [ddms_pkg::CFG_BITS-1:0]          cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [ddms_pkg::OP_BITS-1:0]           operation,
  input  logic [ddms_pkg::RC_BITS-1:0]           steer_raw,
  input  logic [ddms_pkg::RC_BITS-1:0]           throttle_raw,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ddms_pkg::DRIVE_BITS-1:0] left_drive,
  output logic signed [ddms_pkg::DRIVE_BITS-1:0] right_drive,
  output logic                                   drivers_enabled
);

  ddms_pkg::cmd_t    cmd;
  ddms_pkg::status_t status;

  ddms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ddms_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .operation       (operation),
    .steer_raw       (steer_raw),
    .throttle_raw    (throttle_raw),
    .cmd             (cmd),
    .status          (status),
    .left_drive      (left_drive),
    .right_drive     (right_drive),
    .drivers_enabled (drivers_enabled)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the differential drive mixer with slew-rate limit.
`timescale 1ns / 100ps

module testbench;
  import ddms_pkg::*;

  localparam logic [OP_BITS-1:0]      OP_FAILSAFE      = 2'd2;
  localparam logic [OP_BITS-1:0]      OP_SPARE         = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_UNUSED = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_LAST_UNUSED  = 3'd7;
  localparam int RC_MAX   = 2 ** RC_BITS - 1;
  localparam int PWM_MAX  = 2 ** PWM_BITS - 1;
  localparam int HOLD_LEN = 300;

  typedef struct {
    logic [OP_BITS-1:0] op;
    logic [RC_BITS-1:0] steer;
    logic [RC_BITS-1:0] throttle;
  } mix_cmd_t;

  typedef struct {
    logic signed [DRIVE_BITS-1:0] left;
    logic signed [DRIVE_BITS-1:0] right;
    logic                         en;
  } drive_result_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_CENTER;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_BITS-1:0] operation = OP_UPDATE;
  logic [RC_BITS-1:0] steer_raw = '0;
  logic [RC_BITS-1:0] throttle_raw = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DRIVE_BITS-1:0] left_drive;
  logic signed [DRIVE_BITS-1:0] right_drive;
  logic drivers_enabled;

  differential_drive_mixer_slew_core DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .steer_raw(steer_raw), .throttle_raw(throttle_raw),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_drive(left_drive), .right_drive(right_drive),
    .drivers_enabled(drivers_enabled)
  );

  // register copies and drive state of the predictor
  int set_center = 1500;
  int set_range  = 500;
  int set_pwm    = 255;
  int set_dead   = 10;
  int set_slew   = 5;
  int left_level  = 0;
  int right_level = 0;
  bit drv_enabled = 1'b1;

  mix_cmd_t      cmd_queue[$];
  drive_result_t expected_drive[$];

  bit gaps_on = 1'b1;
  int gap_left = 0;
  int hold_left = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int mismatches = 0;
  int results_checked = 0;
  int updates_taken = 0;
  int stops_taken = 0;
  int failsafes_taken = 0;
  int settings_used = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int clamp_mag(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic int scale_stick(logic [RC_BITS-1:0] raw, int lim);
    int centered, span, v;
    centered = int'(raw) - set_center;
    span = (set_range == 0) ? 1 : set_range;
    v = clamp_mag((centered * set_pwm) / span, lim);
    return (((v < 0) ? -v : v) < set_dead) ? 0 : v;
  endfunction

  function automatic int slew_toward(int cur, int tgt);
    if ((cur > 0 && tgt < 0) || (cur < 0 && tgt > 0)) tgt = 0;
    if (cur < tgt) begin
      cur += set_slew;
      if (cur > tgt) cur = tgt;
    end else if (cur > tgt) begin
      cur -= set_slew;
      if (cur < tgt) cur = tgt;
    end
    return cur;
  endfunction

  task automatic mix_and_slew(input mix_cmd_t c);
    int lim, steer, thr;
    drive_result_t r;
    lim = (set_pwm > DRIVE_MAX) ? DRIVE_MAX : set_pwm;
    case (c.op)
      OP_UPDATE: begin
        drv_enabled = 1'b1;
        steer = scale_stick(c.steer, lim);
        thr = scale_stick(c.throttle, lim);
        left_level = slew_toward(left_level, clamp_mag(thr + steer, lim));
        right_level = slew_toward(right_level, clamp_mag(thr - steer, lim));
        updates_taken++;
      end
      OP_STOP: begin
        left_level = slew_toward(left_level, 0);
        right_level = slew_toward(right_level, 0);
        stops_taken++;
      end
      default: begin
        left_level = 0;
        right_level = 0;
        drv_enabled = 1'b0;
        failsafes_taken++;
      end
    endcase
    r.left = DRIVE_BITS'(clamp_mag(left_level, lim));
    r.right = DRIVE_BITS'(clamp_mag(right_level, lim));
    r.en = drv_enabled;
    expected_drive.push_back(r);
  endtask

  function automatic int sender_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input side: offer queued words, predict each accepted one
  always @(posedge clk) begin : cmd_driver
    mix_cmd_t w;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        w.op = operation;
        w.steer = steer_raw;
        w.throttle = throttle_raw;
        mix_and_slew(w);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          w = cmd_queue.pop_front();
          in_valid <= 1'b1;
          operation <= w.op;
          steer_raw <= w.steer;
          throttle_raw <= w.throttle;
          gap_left = sender_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side stall: random short and long stalls, plus requested long holds
  always @(posedge clk) begin : drive_stall_gen
    int r;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (holds_done < hold_requests) begin
      holds_done++;
      hold_left = HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!gaps_on) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_stall <= 1'b0;
      end else if (r < 95) begin
        hold_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        hold_left = $urandom_range(10, 40);
        out_stall <= 1'b1;
      end
    end
  end

  task automatic check_field(input string what, input logic signed [DRIVE_BITS-1:0] want,
                             input logic signed [DRIVE_BITS-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : drive_monitor
    drive_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_drive.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got left %0d right %0d en %0b",
                 $time, left_drive, right_drive, drivers_enabled);
      end else begin
        e = expected_drive.pop_front();
        results_checked++;
        check_field("left_drive", e.left, left_drive);
        check_field("right_drive", e.right, right_drive);
        check_field("drivers_enabled", e.en, drivers_enabled);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_CENTER:    set_center = data;
      REG_SPAN:      set_range = data;
      REG_PWM_MAX:   set_pwm = data[PWM_BITS-1:0];
      REG_DEADZONE:  set_dead = data[PWM_BITS-1:0];
      REG_SLEW_RATE: set_slew = data[PWM_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (cmd_queue.size() != 0 || in_valid || expected_drive.size() != 0)
      @(negedge clk);
  endtask

  task automatic start_batch(input bit gaps, input bit pressure);
    @(negedge clk);
    gaps_on = gaps;
    if (pressure) hold_requests++;
    settings_used++;
  endtask

  task automatic push_cmd(input logic [OP_BITS-1:0] op, input int s, input int t);
    mix_cmd_t c;
    c.op = op;
    c.steer = RC_BITS'(s);
    c.throttle = RC_BITS'(t);
    cmd_queue.push_back(c);
  endtask

  function automatic int pick_setting(int lo_x, int hi_x, int lo, int hi);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return lo_x;
    if (r == 1) return hi_x;
    return $urandom_range(lo, hi);
  endfunction

  // 10-bit registers sometimes get junk in the unused upper data bits
  function automatic logic [CFG_BITS-1:0] narrow_data(int v);
    logic [CFG_BITS-1:0] d;
    d = CFG_BITS'(v);
    if ($urandom_range(0, 3) == 0) d[CFG_BITS-1:PWM_BITS] = (CFG_BITS - PWM_BITS)'($urandom);
    return d;
  endfunction

  task automatic random_settings();
    write_reg(REG_CENTER, CFG_BITS'(pick_setting(0, RC_MAX, 0, RC_MAX)));
    write_reg(REG_SPAN, CFG_BITS'(pick_setting(0, RC_MAX, 1, 1500)));
    write_reg(REG_PWM_MAX, narrow_data(pick_setting(0, PWM_MAX, 1, PWM_MAX)));
    write_reg(REG_DEADZONE, narrow_data(pick_setting(0, PWM_MAX, 0, 40)));
    write_reg(REG_SLEW_RATE, narrow_data(pick_setting(0, PWM_MAX, 1, 120)));
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_BITS'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                CFG_BITS'($urandom));
  endtask

  function automatic int stick_value();
    int span, v;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, RC_MAX);
    span = set_range + set_range / 4 + 8;
    v = set_center + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > RC_MAX) v = RC_MAX;
    return v;
  endfunction

  function automatic logic [OP_BITS-1:0] random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return OP_UPDATE;
    if (r < 90) return OP_STOP;
    if (r < 95) return OP_FAILSAFE;
    return OP_SPARE;
  endfunction

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: extremes, every operation, deadzone, sign reversal
    start_batch(1'b1, 1'b0);
    push_cmd(OP_UPDATE, 1500, 1500);
    push_cmd(OP_UPDATE, RC_MAX, RC_MAX);
    push_cmd(OP_UPDATE, RC_MAX, RC_MAX);
    push_cmd(OP_UPDATE, 1500, 0);
    push_cmd(OP_STOP, RC_MAX, RC_MAX);
    push_cmd(OP_UPDATE, 0, 0);
    push_cmd(OP_UPDATE, 0, RC_MAX);
    push_cmd(OP_FAILSAFE, RC_MAX, 0);
    push_cmd(OP_STOP, 0, 0);
    push_cmd(OP_SPARE, RC_MAX, RC_MAX);
    push_cmd(OP_UPDATE, 1505, 1495);
    push_cmd(OP_UPDATE, RC_MAX, RC_MAX);

    // zero slew: outputs hold
    wait_idle();
    write_reg(REG_SLEW_RATE, '0);
    start_batch(1'b1, 1'b0);
    push_cmd(OP_UPDATE, 0, 0);
    push_cmd(OP_STOP, 0, 0);

    // zero range saturates, full drive both signs
    wait_idle();
    write_reg(REG_SPAN, '0);
    write_reg(REG_PWM_MAX, CFG_BITS'(PWM_MAX));
    write_reg(REG_DEADZONE, '0);
    write_reg(REG_SLEW_RATE, CFG_BITS'(PWM_MAX));
    start_batch(1'b1, 1'b0);
    push_cmd(OP_UPDATE, 1501, 1501);
    push_cmd(OP_UPDATE, 1501, 1500);

    // limit lowered below the stored outputs
    wait_idle();
    write_reg(REG_PWM_MAX, CFG_BITS'(100));
    write_reg(REG_SLEW_RATE, CFG_BITS'(10));
    start_batch(1'b0, 1'b0);
    push_cmd(OP_STOP, 0, 0);
    push_cmd(OP_UPDATE, 1500, 1500);

    // zero pwm_max
    wait_idle();
    write_reg(REG_PWM_MAX, '0);
    start_batch(1'b1, 1'b0);
    push_cmd(OP_UPDATE, RC_MAX, 0);
    push_cmd(OP_UPDATE, 0, RC_MAX);

    // centers at both ends, deadzone at its top, writes to unused indexes
    wait_idle();
    write_reg(REG_CENTER, '0);
    write_reg(REG_SPAN, CFG_BITS'(RC_MAX));
    write_reg(REG_PWM_MAX, CFG_BITS'(PWM_MAX));
    write_reg(REG_DEADZONE, CFG_BITS'(PWM_MAX));
    write_reg(REG_SLEW_RATE, CFG_BITS'(PWM_MAX));
    write_reg(REG_FIRST_UNUSED, '0);
    write_reg(REG_LAST_UNUSED, '1);
    start_batch(1'b1, 1'b0);
    push_cmd(OP_UPDATE, RC_MAX, RC_MAX);
    push_cmd(OP_UPDATE, RC_MAX - 1, RC_MAX - 1);
    wait_idle();
    write_reg(REG_CENTER, CFG_BITS'(RC_MAX));
    start_batch(1'b1, 1'b0);
    push_cmd(OP_UPDATE, 0, 0);
    push_cmd(OP_UPDATE, RC_MAX, 0);

    for (int p = 0; p < 15; p++) begin
      wait_idle();
      random_settings();
      start_batch(p % 4 != 1, p == 3 || p == 10);
      repeat (110) push_cmd(random_op(), stick_value(), stick_value());
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Run covered %0d commands: %0d updates, %0d soft stops, %0d failsafes",
             updates_taken + stops_taken + failsafes_taken, updates_taken, stops_taken,
             failsafes_taken);
    $display("%0d register settings, %0d words checked, %0d mismatches",
             settings_used, results_checked, mismatches);
    if (mismatches == 0 && expected_drive.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
